[src/assert_macros.svh]
// assertion helpers included by the converter top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[src/ryc_pkg.sv]
package ryc_pkg;

    // pixel channel width
    localparam int CH_W = 8;

    // default fraction bits of the fixed-point coefficients
    localparam int COEF_FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STANDARD  = 1'b1;

    // direction and standard codes
    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_INVERSE = 1'b1;
    localparam logic STD_BT601   = 1'b0;
    localparam logic STD_BT709   = 1'b1;

endpackage

[src/ryc_if.sv]
// input word: three channels, valid/ready handshake
interface ryc_in_if;
    logic                    valid;
    logic                    ready;
    logic [ryc_pkg::CH_W-1:0] first_channel;
    logic [ryc_pkg::CH_W-1:0] second_channel;
    logic [ryc_pkg::CH_W-1:0] third_channel;

    modport source (output valid, output first_channel, output second_channel,
                    output third_channel, input ready);
    modport sink   (input valid, input first_channel, input second_channel,
                    input third_channel, output ready);
endinterface

// output word: three channels, valid/ready handshake
interface ryc_out_if;
    logic                    valid;
    logic                    ready;
    logic [ryc_pkg::CH_W-1:0] out_first;
    logic [ryc_pkg::CH_W-1:0] out_second;
    logic [ryc_pkg::CH_W-1:0] out_third;

    modport source (output valid, output out_first, output out_second,
                    output out_third, input ready);
    modport sink   (input valid, input out_first, input out_second,
                    input out_third, output ready);
endinterface

[src/rgb_ycbcr_converter_top.sv]
// rgb <-> ycbcr full-range converter, bt.601 / bt.709 coefficients
// an accepted input word passes through the operand, product, sum and clamp registers to the output
// throughput: one word per cycle while the output is taken, set by the 4-stage operand/multiply/sum/clamp pipeline
// per-stage ready lets bubbles collapse; a waiting output word stalls only full stages behind it
// reset (synchronous, active low) empties the pipeline and selects forward bt.601
`include "assert_macros.svh"

module rgb_ycbcr_converter_top #(
    parameter int COEF_FRAC_BITS = ryc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ryc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ryc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ryc_in_if.sink                         i_pix,
    ryc_out_if.source                      o_pix
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int OW = ryc_pkg::CH_W + 1;   // signed operand width
    localparam int CW = F + 2;               // signed coefficient width
    localparam int PW = CW + OW;             // product width
    localparam int AW = PW + 2;              // accumulator width

    // coefficients, rounded half up on magnitude
    localparam logic signed [CW-1:0] C_ZERO = '0;
    localparam logic signed [CW-1:0] C_ONE  = CW'(64'sd1 <<< F);
    localparam logic signed [CW-1:0] C_HALF = CW'(((64'sd1 <<< F) + 1) / 2);

    localparam logic signed [CW-1:0] C_YR_601 = CW'(((64'sd2990 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_YG_601 = CW'(((64'sd5870 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_YB_601 = CW'(((64'sd1140 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_YR_709 = CW'(((64'sd2126 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_YG_709 = CW'(((64'sd7152 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_YB_709 = CW'(((64'sd722 <<< F) + 5000) / 10000);

    localparam logic signed [CW-1:0] C_CBR_601 = -CW'(((64'sd2990 <<< F) + 8860) / 17720);
    localparam logic signed [CW-1:0] C_CBG_601 = -CW'(((64'sd5870 <<< F) + 8860) / 17720);
    localparam logic signed [CW-1:0] C_CRG_601 = -CW'(((64'sd5870 <<< F) + 7010) / 14020);
    localparam logic signed [CW-1:0] C_CRB_601 = -CW'(((64'sd1140 <<< F) + 7010) / 14020);
    localparam logic signed [CW-1:0] C_CBR_709 = -CW'(((64'sd2126 <<< F) + 9278) / 18556);
    localparam logic signed [CW-1:0] C_CBG_709 = -CW'(((64'sd7152 <<< F) + 9278) / 18556);
    localparam logic signed [CW-1:0] C_CRG_709 = -CW'(((64'sd7152 <<< F) + 7874) / 15748);
    localparam logic signed [CW-1:0] C_CRB_709 = -CW'(((64'sd722 <<< F) + 7874) / 15748);

    localparam logic signed [CW-1:0] C_RCR_601 = CW'(((64'sd14020 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_BCB_601 = CW'(((64'sd17720 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_GCB_601 =
        -CW'(((64'sd20200800 <<< F) + 29350000) / 58700000);
    localparam logic signed [CW-1:0] C_GCR_601 =
        -CW'(((64'sd41919800 <<< F) + 29350000) / 58700000);
    localparam logic signed [CW-1:0] C_RCR_709 = CW'(((64'sd15748 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_BCB_709 = CW'(((64'sd18556 <<< F) + 5000) / 10000);
    localparam logic signed [CW-1:0] C_GCB_709 =
        -CW'(((64'sd13397432 <<< F) + 35760000) / 71520000);
    localparam logic signed [CW-1:0] C_GCR_709 =
        -CW'(((64'sd33480248 <<< F) + 35760000) / 71520000);

    // rounding half and chroma offset folded into one bias
    localparam logic signed [AW-1:0] C_RND = AW'(64'sd1 <<< (F - 1));
    localparam logic signed [AW-1:0] C_OFF = AW'((64'sd128 <<< F) + (64'sd1 <<< (F - 1)));

    // configuration registers
    logic r_direction;
    logic r_standard;

    // pipeline registers
    logic                    r_v0, r_v1, r_v2, r_v3;
    logic signed [OW-1:0]    r_op   [3];
    logic signed [PW-1:0]    r_prod [3][3];
    logic signed [AW-1:0]    r_acc  [3];
    logic [ryc_pkg::CH_W-1:0] r_out [3];

    logic signed [OW-1:0]    n_op   [3];
    logic signed [PW-1:0]    n_prod [3][3];
    logic signed [AW-1:0]    n_acc  [3];
    logic [ryc_pkg::CH_W-1:0] n_out [3];

    logic signed [CW-1:0]    w_coef [3][3];
    logic signed [AW-1:0]    w_bias [3];
    logic                    w_rdy0, w_rdy1, w_rdy2, w_rdy3;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= ryc_pkg::DIR_FORWARD;
            r_standard  <= ryc_pkg::STD_BT601;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ryc_pkg::REG_DIRECTION: r_direction <= i_cfg_data[0];
                ryc_pkg::REG_STANDARD:  r_standard  <= i_cfg_data[0];
            endcase
        end
    end

    // per-stage ready chain
    assign w_rdy3 = !r_v3 || o_pix.ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign i_pix.ready = w_rdy0;

    // coefficient matrix and bias for the current mode
    always_comb begin
        unique case ({r_direction, r_standard})
            {ryc_pkg::DIR_FORWARD, ryc_pkg::STD_BT601}: begin
                w_coef[0] = '{C_YR_601, C_YG_601, C_YB_601};
                w_coef[1] = '{C_CBR_601, C_CBG_601, C_HALF};
                w_coef[2] = '{C_HALF, C_CRG_601, C_CRB_601};
            end
            {ryc_pkg::DIR_FORWARD, ryc_pkg::STD_BT709}: begin
                w_coef[0] = '{C_YR_709, C_YG_709, C_YB_709};
                w_coef[1] = '{C_CBR_709, C_CBG_709, C_HALF};
                w_coef[2] = '{C_HALF, C_CRG_709, C_CRB_709};
            end
            {ryc_pkg::DIR_INVERSE, ryc_pkg::STD_BT601}: begin
                w_coef[0] = '{C_ONE, C_ZERO, C_RCR_601};
                w_coef[1] = '{C_ONE, C_GCB_601, C_GCR_601};
                w_coef[2] = '{C_ONE, C_BCB_601, C_ZERO};
            end
            {ryc_pkg::DIR_INVERSE, ryc_pkg::STD_BT709}: begin
                w_coef[0] = '{C_ONE, C_ZERO, C_RCR_709};
                w_coef[1] = '{C_ONE, C_GCB_709, C_GCR_709};
                w_coef[2] = '{C_ONE, C_BCB_709, C_ZERO};
            end
        endcase
        w_bias[0] = C_RND;
        w_bias[1] = (r_direction == ryc_pkg::DIR_FORWARD) ? C_OFF : C_RND;
        w_bias[2] = (r_direction == ryc_pkg::DIR_FORWARD) ? C_OFF : C_RND;
    end

    // stage 0: operands, chroma offset removed on inverse
    always_comb begin
        n_op[0] = $signed({1'b0, i_pix.first_channel});
        n_op[1] = $signed({1'b0, i_pix.second_channel});
        n_op[2] = $signed({1'b0, i_pix.third_channel});
        if (r_direction == ryc_pkg::DIR_INVERSE) begin
            n_op[1] = n_op[1] - OW'(128);
            n_op[2] = n_op[2] - OW'(128);
        end
    end

    // stage 1: nine products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = PW'(w_coef[i][j]) * PW'(r_op[j]);
            end
        end
    end

    // stage 2: per-channel sum with bias
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = AW'(r_prod[i][0]) + AW'(r_prod[i][1]) + AW'(r_prod[i][2]) + w_bias[i];
        end
    end

    // stage 3: drop fraction and clamp to 0..255
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_acc[i][AW-1]) begin
                n_out[i] = '0;
            end else if (|r_acc[i][AW-2:F+ryc_pkg::CH_W]) begin
                n_out[i] = '1;
            end else begin
                n_out[i] = r_acc[i][F+ryc_pkg::CH_W-1:F];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_pix.valid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy0) r_op   <= n_op;
        if (w_rdy1) r_prod <= n_prod;
        if (w_rdy2) r_acc  <= n_acc;
        if (w_rdy3) r_out  <= n_out;
    end

    assign o_pix.valid      = r_v3;
    assign o_pix.out_first  = r_out[0];
    assign o_pix.out_second = r_out[1];
    assign o_pix.out_third  = r_out[2];

    // input stalls only when every stage is full and the output is held
    `ASSERT_PROP(a_full_stall, i_clk, i_rst_n,
        !i_pix.ready |-> (r_v0 && r_v1 && r_v2 && r_v3 && !o_pix.ready),
        "input stalled while pipeline has room")
    // an accepted word lands in stage 0
    `ASSERT_PROP(a_accept_lands, i_clk, i_rst_n,
        (i_pix.valid && i_pix.ready) |=> r_v0, "accepted word lost at stage 0")
    // a word moving out of the product stage is not dropped
    `ASSERT_PROP(a_prod_moves, i_clk, i_rst_n,
        (r_v1 && w_rdy2) |=> r_v2, "word lost between product and sum stages")
    // a negative first-channel sum clamps to zero
    `ASSERT_PROP(a_clamp_low, i_clk, i_rst_n,
        (r_v2 && w_rdy3 && r_acc[0][AW-1]) |=> (o_pix.out_first == '0),
        "negative sum not clamped to zero")

endmodule
